// ===== sv/bitbang_sync_packet_link_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bit-bang sync packet link
// Concurrent assertion wrappers that compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef BITBANG_SYNC_PACKET_LINK_CORE_MACROS_SVH
`define BITBANG_SYNC_PACKET_LINK_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge while reset is released.
`define BSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bitbang_sync_packet_link_core: assertion failed");

// Checked on every clock edge, reset included.
`define BSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bitbang_sync_packet_link_core: assertion failed");

`else

`define BSP_ASSERT(lbl, prop)
`define BSP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== sv/bsplink_pkg.sv =====
// ---------------------------------------------------------------------------
// Bit-bang sync packet link package
// Shared types, constants and the beacon bit function.
// ---------------------------------------------------------------------------
package bsplink_pkg;

  localparam logic [7:0]  BEACON_LEN   = 8'd5;
  localparam logic [5:0]  BEACON_BITS  = 6'd40;
  localparam logic [7:0]  SYNC_RESET   = 8'd170;
  localparam logic [15:0] PERIOD_RESET = 16'd500;
  localparam logic [7:0]  MIN_LENGTH   = 8'd2;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SYNC_ERR  = 3'd1,
    EV_GOOD      = 3'd2,
    EV_CSUM_BAD  = 3'd3,
    EV_LEN_BAD   = 3'd4
  } rx_event_e;

  typedef enum logic [1:0] {
    REG_LINK_ENABLE    = 2'd0,
    REG_BEACON_PERIOD  = 2'd1,
    REG_SYNC_BYTE      = 2'd2,
    REG_BEACON_PAYLOAD = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic      byte_valid;
    logic [7:0] data;
    rx_event_e event_code;
  } rx_result_t;

  // Bit of the five-byte beacon at bit position idx, MSB of each byte first.
  function automatic logic beacon_bit(logic [5:0] idx, logic [7:0] sync_b,
                                      logic [7:0] payload);
    logic [9:0] sum;
    logic [7:0] b;
    sum = {2'b00, sync_b} + {2'b00, BEACON_LEN} + {2'b00, payload};
    case (idx[5:3])
      3'd0:    b = sync_b;
      3'd1:    b = BEACON_LEN;
      3'd2:    b = payload;
      3'd3:    b = {5'd0, sum[9:7]};
      default: b = {1'b0, sum[6:0]};
    endcase
    return b[~idx[2:0]];
  endfunction

endpackage

// ===== sv/bsplink_rx.sv =====
// ---------------------------------------------------------------------------
// Bit-bang sync packet link receiver
// Assembles received bits into bytes and checks sync, length and checksum.
// ---------------------------------------------------------------------------
module bsplink_rx (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic                    rx_bit_i,
  input  logic [7:0]              sync_byte_i,
  output bsplink_pkg::rx_result_t result_o
);

  logic        receiving_q, receiving_d;
  logic [10:0] idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  rec0_q, rec0_d;
  logic [7:0]  rec1_q, rec1_d;

  always_comb begin
    logic active;
    logic pkt_end;
    result_o    = '0;
    receiving_d = receiving_q;
    idx_d       = idx_q;
    len_d       = len_q;
    shift_d     = shift_q;
    first_d     = first_q;
    sum_d       = sum_q;
    rec0_d      = rec0_q;
    rec1_d      = rec1_q;
    pkt_end     = 1'b0;
    if (tick_i && rx_bit_i && !receiving_q) begin
      receiving_d = 1'b1;
      idx_d       = '0;
      len_d       = bsplink_pkg::MIN_LENGTH;
      shift_d     = '0;
      first_d     = '0;
      sum_d       = '0;
      rec0_d      = '0;
      rec1_d      = '0;
    end
    active = tick_i && receiving_d;
    if (active) begin
      if (idx_d < {len_d, 3'b000}) begin
        shift_d = {shift_d[6:0], rx_bit_i};
        if (idx_d[2:0] == 3'd7) begin
          result_o.byte_valid = 1'b1;
          result_o.data       = shift_d;
          // The last two bytes are held back so they never enter the sum.
          sum_d  = sum_d + {8'd0, rec0_d};
          rec0_d = rec1_d;
          rec1_d = shift_d;
          if (idx_d == 11'd7) begin
            first_d = shift_d;
          end
        end
        if (idx_d == 11'd15) begin
          if (first_d != sync_byte_i) begin
            result_o.event_code = bsplink_pkg::EV_SYNC_ERR;
            pkt_end = 1'b1;
          end else if (shift_d < bsplink_pkg::MIN_LENGTH) begin
            result_o.event_code = bsplink_pkg::EV_LEN_BAD;
            pkt_end = 1'b1;
          end else begin
            len_d = shift_d;
          end
        end
      end else if (idx_d == {len_d, 3'b000}) begin
        if (rec0_d == sum_d[14:7] && rec1_d == {1'b0, sum_d[6:0]}) begin
          result_o.event_code = bsplink_pkg::EV_GOOD;
        end else begin
          result_o.event_code = bsplink_pkg::EV_CSUM_BAD;
        end
        pkt_end = 1'b1;
      end
      if (pkt_end) begin
        receiving_d = 1'b0;
        idx_d       = '0;
      end else begin
        idx_d = idx_d + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      idx_q       <= '0;
      len_q       <= bsplink_pkg::MIN_LENGTH;
      shift_q     <= '0;
      first_q     <= '0;
      sum_q       <= '0;
      rec0_q      <= '0;
      rec1_q      <= '0;
    end else if (tick_i) begin
      receiving_q <= receiving_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      shift_q     <= shift_d;
      first_q     <= first_d;
      sum_q       <= sum_d;
      rec0_q      <= rec0_d;
      rec1_q      <= rec1_d;
    end
  end

endmodule

// ===== sv/bitbang_sync_packet_link_core.sv =====
// ---------------------------------------------------------------------------
// Bit-bang sync packet link core
// Alternating transmit and receive ticks with a periodic five-byte beacon.
// ---------------------------------------------------------------------------
// Each input word is one tick and yields exactly one result word. A tick is
// handled at its accepting edge: the link state updates at that edge and the
// result lands in the output register, so one word per clock is sustained;
// in_ready_o stays high whenever the output register is empty or is being
// drained in the same cycle. The first result appears in the cycle after
// acceptance. Registers sit on an APB port at byte addresses 0, 4, 8 and 12.
`include "bitbang_sync_packet_link_core_macros.svh"

module bitbang_sync_packet_link_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        rx_bit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_bit_o,
  output logic        tx_clock_o,
  output logic        rx_byte_valid_o,
  output logic [7:0]  rx_byte_o,
  output logic [2:0]  rx_event_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        link_enable_q;
  logic [15:0] beacon_period_q;
  logic [7:0]  sync_byte_q;
  logic [7:0]  beacon_payload_q;

  logic        phase_q, phase_d;
  logic        clock_level_q, clock_level_d;
  logic        data_level_q, data_level_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic        armed_q, armed_d;
  logic [5:0]  tx_idx_q, tx_idx_d;

  logic        out_valid_q;
  logic        rx_valid_q;
  logic [7:0]  rx_byte_q;
  logic [2:0]  rx_event_q;

  logic        in_fire;
  logic        cfg_write;
  logic        rx_tick;
  bsplink_pkg::rx_result_t rx_res;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign rx_tick    = in_fire && link_enable_q && phase_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_enable_q    <= 1'b1;
      beacon_period_q  <= bsplink_pkg::PERIOD_RESET;
      sync_byte_q      <= bsplink_pkg::SYNC_RESET;
      beacon_payload_q <= '0;
    end else if (cfg_write) begin
      case (bsplink_pkg::reg_idx_e'(paddr[3:2]))
        bsplink_pkg::REG_LINK_ENABLE:    link_enable_q    <= pwdata[0];
        bsplink_pkg::REG_BEACON_PERIOD:  beacon_period_q  <= pwdata[15:0];
        bsplink_pkg::REG_SYNC_BYTE:      sync_byte_q      <= pwdata[7:0];
        bsplink_pkg::REG_BEACON_PAYLOAD: beacon_payload_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bsplink_pkg::reg_idx_e'(paddr[3:2]))
      bsplink_pkg::REG_LINK_ENABLE:    prdata = {31'd0, link_enable_q};
      bsplink_pkg::REG_BEACON_PERIOD:  prdata = {16'd0, beacon_period_q};
      bsplink_pkg::REG_SYNC_BYTE:      prdata = {24'd0, sync_byte_q};
      bsplink_pkg::REG_BEACON_PAYLOAD: prdata = {24'd0, beacon_payload_q};
      default:                         prdata = '0;
    endcase
  end

  // Transmit side and beacon scheduling.
  always_comb begin
    phase_d       = phase_q;
    clock_level_d = clock_level_q;
    data_level_d  = data_level_q;
    tick_count_d  = tick_count_q;
    armed_d       = armed_q;
    tx_idx_d      = tx_idx_q;
    if (link_enable_q) begin
      if (!phase_q) begin
        clock_level_d = !clock_level_q;
        if (armed_q && tx_idx_q < bsplink_pkg::BEACON_BITS) begin
          data_level_d = bsplink_pkg::beacon_bit(tx_idx_q, sync_byte_q,
                                                 beacon_payload_q);
          tx_idx_d     = tx_idx_q + 6'd1;
        end else begin
          data_level_d = 1'b0;
        end
      end
      phase_d      = !phase_q;
      tick_count_d = tick_count_q + 16'd1;
      if (tick_count_d == beacon_period_q) begin
        tick_count_d = '0;
        tx_idx_d     = '0;
        armed_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= 1'b0;
      clock_level_q <= 1'b0;
      data_level_q  <= 1'b0;
      tick_count_q  <= '0;
      armed_q       <= 1'b0;
      tx_idx_q      <= '0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      clock_level_q <= clock_level_d;
      data_level_q  <= data_level_d;
      tick_count_q  <= tick_count_d;
      armed_q       <= armed_d;
      tx_idx_q      <= tx_idx_d;
    end
  end

  bsplink_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (rx_tick),
    .rx_bit_i    (rx_bit_i),
    .sync_byte_i (sync_byte_q),
    .result_o    (rx_res)
  );

  // Output register; the line levels are read straight from the link state,
  // which only moves together with this register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rx_valid_q <= rx_res.byte_valid;
      rx_byte_q  <= rx_res.data;
      rx_event_q <= rx_res.event_code;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_bit_o        = data_level_q;
  assign tx_clock_o      = clock_level_q;
  assign rx_byte_valid_o = rx_valid_q;
  assign rx_byte_o       = rx_byte_q;
  assign rx_event_o      = rx_event_q;

  `BSP_ASSERT(a_tx_tick_no_rx, in_fire && !phase_q |=> !rx_byte_valid_o && !(|rx_event_o))
  `BSP_ASSERT(a_tx_clock_toggles, in_fire && link_enable_q && !phase_q |=> !$stable(tx_clock_o))
  `BSP_ASSERT(a_tx_idx_bound, tx_idx_q <= bsplink_pkg::BEACON_BITS)

endmodule
